@@ design/lgge_pkg.sv @@
// ----------------------------------------------------------------------------
// lgge_pkg
// Shared action codes, status codes and rule constants for the Life grid engine.
// ----------------------------------------------------------------------------
package lgge_pkg;

    // Action codes carried by each request.
    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_SET     = 2'd1,
        ACT_ADVANCE = 2'd2,
        ACT_READ    = 2'd3
    } action_t;

    // Result status codes.
    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_BAD_OFFSET = 1'b1;

    // Neighbor counts of the rule: survival on two or three, birth on three.
    localparam logic [3:0] NBR_SURVIVE = 4'd2;
    localparam logic [3:0] NBR_BIRTH   = 4'd3;

endpackage

@@ design/lgge_row_mem.sv @@
// ----------------------------------------------------------------------------
// lgge_row_mem
// Row store of the grid: one write and one registered read port per cycle.
// A row that was never written since reset or the last clear reads as zero.
// ----------------------------------------------------------------------------
module lgge_row_mem #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     clear_all,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] row_valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Per-row valid bits stand in for a clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
            if (clear_all)
            begin
                row_valid_reg <= '0;
            end
            else if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ design/lgge_row_calc.sv @@
// ----------------------------------------------------------------------------
// lgge_row_calc
// Next-generation value of one row from the row above, the row itself and
// the row below. Cells beyond the left and right edges count as dead.
// ----------------------------------------------------------------------------
module lgge_row_calc
    import lgge_pkg::*;
#(
    parameter int GRID_SIZE = 16
) (
    input  logic [GRID_SIZE-1:0] above,
    input  logic [GRID_SIZE-1:0] middle,
    input  logic [GRID_SIZE-1:0] below,
    output logic [GRID_SIZE-1:0] next_row
);

    logic [GRID_SIZE+1:0] above_pad;
    logic [GRID_SIZE+1:0] middle_pad;
    logic [GRID_SIZE+1:0] below_pad;

    assign above_pad  = {1'b0, above, 1'b0};
    assign middle_pad = {1'b0, middle, 1'b0};
    assign below_pad  = {1'b0, below, 1'b0};

    always_comb
    begin
        logic [3:0] nbr;
        next_row = '0;
        for (int c = 0; c < GRID_SIZE; c++)
        begin
            nbr = 4'(above_pad[c]) + 4'(above_pad[c+1]) + 4'(above_pad[c+2])
                + 4'(middle_pad[c]) + 4'(middle_pad[c+2])
                + 4'(below_pad[c]) + 4'(below_pad[c+1]) + 4'(below_pad[c+2]);
            if (middle[c])
            begin
                next_row[c] = (nbr == NBR_SURVIVE) || (nbr == NBR_BIRTH);
            end
            else
            begin
                next_row[c] = (nbr == NBR_BIRTH);
            end
        end
    end

endmodule

@@ design/life_grid_generation_engine.sv @@
// ----------------------------------------------------------------------------
// life_grid_generation_engine
// Conway's Game of Life on a bounded square grid held in a row memory.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge where start is high and busy is low;
// action and cell_offset are sampled there. Every request produces exactly
// one result, shown on status and cell_alive for one cycle while done is
// high. The receiver cannot stall, so results are never held back.
// Sequence of each action after the accepting edge:
//   clear:         busy never rises; the result appears the next cycle.
//   set or read:   busy through the reciprocal-multiply estimate, the
//                  remainder, the correction with the memory read, and the
//                  read-modify-write; the result appears the cycle after.
//                  An out-of-range offset skips all that and answers the next cycle.
//   advance:       busy while the single memory read port streams every row
//                  once through a three-row window.
// A new request may be taken in the same cycle the previous result is shown.
// Reset leaves every cell dead at once: per-row valid bits in the memory are
// cleared, so no clearing pass is needed and the block is ready right away.
// ----------------------------------------------------------------------------
module life_grid_generation_engine
    import lgge_pkg::*;
#(
    parameter int GRID_SIZE = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [15:0] cell_offset,
    output logic        done,
    output logic        status,
    output logic        cell_alive
);

    localparam int RW   = $clog2(GRID_SIZE);
    localparam int AREA = GRID_SIZE * GRID_SIZE;
    localparam int AW   = $clog2(AREA);
    localparam int CW   = $clog2(GRID_SIZE + 2);

    // Reciprocal of the grid size scaled by 2^AW. Since every in-range offset
    // is below 2^AW, the estimated row is exact or one short.
    localparam logic [AW-1:0]   RECIP    = AW'((1 << AW) / GRID_SIZE);
    localparam logic [AW-1:0]   GRID_AW  = AW'(GRID_SIZE);
    localparam logic [RW:0]     GRID_REM = (RW + 1)'(GRID_SIZE);
    localparam logic [CW-1:0]   GRID_CNT = CW'(GRID_SIZE);
    localparam logic [CW-1:0]   LAST_CNT = CW'(GRID_SIZE + 1);
    localparam logic [15:0]     AREA_OFF = 16'(AREA);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_Q,
        S_DIV_R,
        S_ADDR,
        S_ACCESS,
        S_GEN
    } state_t;

    state_t                state_reg;
    logic                  set_reg;
    logic [AW-1:0]         off_reg;
    logic [RW-1:0]         q0_reg;
    logic [RW:0]           rem_reg;
    logic [RW-1:0]         row_reg;
    logic [RW-1:0]         col_reg;
    logic [CW-1:0]         gen_cnt_reg;
    logic [GRID_SIZE-1:0]  prev_reg;
    logic [GRID_SIZE-1:0]  cur_reg;
    logic                  done_reg;
    logic                  status_reg;
    logic                  alive_reg;

    logic                  clear_all;
    logic                  rd_en;
    logic [RW-1:0]         rd_addr;
    logic [GRID_SIZE-1:0]  rd_data;
    logic                  wr_en;
    logic [RW-1:0]         wr_addr;
    logic [GRID_SIZE-1:0]  wr_data;

    logic [2*AW-1:0]       quot_prod;
    logic [AW-1:0]         rem_full;
    logic                  rem_over;
    logic [RW-1:0]         row_fix;
    logic [RW-1:0]         col_fix;
    logic [GRID_SIZE-1:0]  upd_row;
    logic [GRID_SIZE-1:0]  incoming;
    logic [GRID_SIZE-1:0]  calc_row;

    // Row and column split: estimate, remainder, then one correction step.
    assign quot_prod = (2 * AW)'(off_reg) * (2 * AW)'(RECIP);
    assign rem_full  = off_reg - AW'(q0_reg) * GRID_AW;
    assign rem_over  = (rem_reg >= GRID_REM);
    assign row_fix   = rem_over ? (q0_reg + RW'(1)) : q0_reg;
    assign col_fix   = rem_over ? RW'(rem_reg - GRID_REM) : rem_reg[RW-1:0];

    // Read-modify-write of the addressed row for a set request.
    assign upd_row = rd_data | (set_reg ? (GRID_SIZE'(1) << col_reg) : '0);

    // In a generation, the row read on the previous cycle enters the window.
    // Past the last row the window sees a dead border row instead.
    assign incoming = ((gen_cnt_reg != '0) && (gen_cnt_reg <= GRID_CNT)) ? rd_data : '0;

    lgge_row_calc #(
        .GRID_SIZE(GRID_SIZE)
    ) u_row_calc (
        .above    (prev_reg),
        .middle   (cur_reg),
        .below    (incoming),
        .next_row (calc_row)
    );

    lgge_row_mem #(
        .WIDTH(GRID_SIZE),
        .DEPTH(GRID_SIZE)
    ) u_row_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear_all (clear_all),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    assign clear_all = (state_reg == S_IDLE) && start && (action == ACT_CLEAR);

    // Memory port control. During a generation, row c is read while row c-2
    // is written back; the old contents of row c-2 already sit in the window.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        case (state_reg)
            S_ADDR:
            begin
                rd_en   = 1'b1;
                rd_addr = row_fix;
            end
            S_ACCESS:
            begin
                wr_en   = set_reg;
                wr_addr = row_reg;
                wr_data = upd_row;
            end
            S_GEN:
            begin
                if (gen_cnt_reg < GRID_CNT)
                begin
                    rd_en   = 1'b1;
                    rd_addr = gen_cnt_reg[RW-1:0];
                end
                if (gen_cnt_reg >= CW'(2))
                begin
                    wr_en   = 1'b1;
                    wr_addr = RW'(gen_cnt_reg - CW'(2));
                    wr_data = calc_row;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            set_reg     <= 1'b0;
            off_reg     <= '0;
            q0_reg      <= '0;
            rem_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            gen_cnt_reg <= '0;
            prev_reg    <= '0;
            cur_reg     <= '0;
            done_reg    <= 1'b0;
            status_reg  <= STATUS_OK;
            alive_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        set_reg <= (action == ACT_SET);
                        off_reg <= cell_offset[AW-1:0];
                        case (action)
                            ACT_CLEAR:
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= STATUS_OK;
                                alive_reg  <= 1'b0;
                            end
                            ACT_ADVANCE:
                            begin
                                gen_cnt_reg <= '0;
                                prev_reg    <= '0;
                                cur_reg     <= '0;
                                state_reg   <= S_GEN;
                            end
                            default:
                            begin
                                if (cell_offset >= AREA_OFF)
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= STATUS_BAD_OFFSET;
                                    alive_reg  <= 1'b0;
                                end
                                else
                                begin
                                    state_reg <= S_DIV_Q;
                                end
                            end
                        endcase
                    end
                end
                S_DIV_Q:
                begin
                    q0_reg    <= quot_prod[AW +: RW];
                    state_reg <= S_DIV_R;
                end
                S_DIV_R:
                begin
                    rem_reg   <= rem_full[RW:0];
                    state_reg <= S_ADDR;
                end
                S_ADDR:
                begin
                    row_reg   <= row_fix;
                    col_reg   <= col_fix;
                    state_reg <= S_ACCESS;
                end
                S_ACCESS:
                begin
                    done_reg   <= 1'b1;
                    status_reg <= STATUS_OK;
                    alive_reg  <= upd_row[col_reg];
                    state_reg  <= S_IDLE;
                end
                S_GEN:
                begin
                    prev_reg <= cur_reg;
                    cur_reg  <= incoming;
                    if (gen_cnt_reg == LAST_CNT)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= STATUS_OK;
                        alive_reg  <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        gen_cnt_reg <= gen_cnt_reg + CW'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign cell_alive = alive_reg;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Request-level testbench for the Life grid generation engine.
// ----------------------------------------------------------------------------
// A queue of pending requests is filled up front. It starts with a short
// directed list covering the grid corners, the first offset past the grid,
// the largest offset, the no-wrap border and every action. It continues with
// random episodes: patterns are placed, possibly straddling the border, then
// advanced and probed with reads, mixed with random noise requests. A
// clocked driver feeds the block with random gaps. It keeps a shadow copy of
// the grid and works out the expected status and cell state at the moment
// each request is taken. A clocked monitor compares every result against
// the oldest expectation.
// ----------------------------------------------------------------------------
module tb
    import lgge_pkg::*;
();

    localparam int GRID         = 16;
    localparam int GRID_AREA    = GRID * GRID;
    localparam int RANDOM_REQS  = 750;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 4 * GRID;

    // Neighbor counts of the rule.
    localparam int KEEP_LO = 2;
    localparam int KEEP_HI = 3;
    localparam int BORN_AT = 3;

    // Pattern kinds placed by the random episodes.
    localparam int PAT_BLINKER = 0;
    localparam int PAT_BLOCK   = 1;
    localparam int PAT_GLIDER  = 2;
    localparam int PAT_BLOB    = 3;
    localparam int PAT_SINGLE  = 4;

    typedef struct {
        action_t     act;
        logic [15:0] offset;
        bit          drain;     // hold this request back until nothing is outstanding
    } life_request_t;

    typedef struct {
        action_t     act;
        logic [15:0] offset;
        logic        status;
        logic        alive;
    } cell_answer_t;

    logic        clk;
    logic        rst_n;
    logic        start       = 1'b0;
    logic [1:0]  action      = ACT_CLEAR;
    logic [15:0] cell_offset = '0;
    logic        busy;
    logic        done;
    logic        status;
    logic        cell_alive;

    life_request_t   pending_reqs[$];
    cell_answer_t    awaited_answers[$];
    logic [GRID-1:0] shadow_rows [GRID];

    int requests_taken = 0;
    int answers_seen   = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;

    // Driver-private pacing state.
    int gap_left      = 0;
    int mode_left     = 0;
    bit no_gap_stretch = 1'b0;

    life_grid_generation_engine #(
        .GRID_SIZE(GRID)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .cell_offset(cell_offset),
        .done       (done),
        .status     (status),
        .cell_alive (cell_alive)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Shadow grid
    // ------------------------------------------------------------------------

    // Cells beyond the border read as dead; there is no wrap-around.
    function automatic int shadow_cell(int r, int c);
        if (r < 0 || r >= GRID || c < 0 || c >= GRID)
            return 0;
        return int'(shadow_rows[r][c]);
    endfunction

    // Applies one request to the shadow grid and returns the answer the block
    // must give for it.
    task automatic apply_to_shadow_grid(input action_t act, input logic [15:0] off,
                                        output cell_answer_t ans);
        logic [GRID-1:0] next_rows [GRID];
        int              r;
        int              c;
        int              nbrs;
        int              row_i;
        int              col_i;
        ans.act    = act;
        ans.offset = off;
        ans.status = STATUS_OK;
        ans.alive  = 1'b0;
        case (act)
            ACT_CLEAR:
            begin
                for (r = 0; r < GRID; r++)
                    shadow_rows[r] = '0;
            end
            ACT_ADVANCE:
            begin
                // The whole next generation is built from the old one before
                // anything is written back.
                for (r = 0; r < GRID; r++)
                begin
                    for (c = 0; c < GRID; c++)
                    begin
                        nbrs = shadow_cell(r - 1, c - 1) + shadow_cell(r - 1, c)
                             + shadow_cell(r - 1, c + 1) + shadow_cell(r, c - 1)
                             + shadow_cell(r, c + 1) + shadow_cell(r + 1, c - 1)
                             + shadow_cell(r + 1, c) + shadow_cell(r + 1, c + 1);
                        if (shadow_rows[r][c])
                            next_rows[r][c] = (nbrs == KEEP_LO || nbrs == KEEP_HI);
                        else
                            next_rows[r][c] = (nbrs == BORN_AT);
                    end
                end
                for (r = 0; r < GRID; r++)
                    shadow_rows[r] = next_rows[r];
            end
            default:
            begin
                // Set and read share the offset check; past the grid nothing moves.
                if (off >= GRID_AREA)
                begin
                    ans.status = STATUS_BAD_OFFSET;
                end
                else
                begin
                    row_i = off / GRID;
                    col_i = off % GRID;
                    if (act == ACT_SET)
                        shadow_rows[row_i][col_i] = 1'b1;
                    ans.alive = shadow_rows[row_i][col_i];
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------

    task automatic queue_request(input action_t act, input logic [15:0] off, input bit drain);
        life_request_t req;
        req.act    = act;
        req.offset = off;
        req.drain  = drain;
        pending_reqs.push_back(req);
    endtask

    // Cells that fall outside the grid are simply dropped, so patterns can
    // be clipped against any border.
    task automatic queue_set_cell(input int r, input int c);
        if (r >= 0 && r < GRID && c >= 0 && c < GRID)
            queue_request(ACT_SET, 16'(r * GRID + c), $urandom_range(0, 39) == 0);
    endtask

    task automatic queue_pattern(input int kind, input int r0, input int c0);
        int dr;
        int dc;
        case (kind)
            PAT_BLINKER:
            begin
                if ($urandom_range(0, 1))
                    for (dc = 0; dc < 3; dc++) queue_set_cell(r0, c0 + dc);
                else
                    for (dr = 0; dr < 3; dr++) queue_set_cell(r0 + dr, c0);
            end
            PAT_BLOCK:
            begin
                for (dr = 0; dr < 2; dr++)
                    for (dc = 0; dc < 2; dc++)
                        queue_set_cell(r0 + dr, c0 + dc);
            end
            PAT_GLIDER:
            begin
                queue_set_cell(r0, c0 + 1);
                queue_set_cell(r0 + 1, c0 + 2);
                queue_set_cell(r0 + 2, c0);
                queue_set_cell(r0 + 2, c0 + 1);
                queue_set_cell(r0 + 2, c0 + 2);
            end
            PAT_BLOB:
            begin
                for (dr = 0; dr < 4; dr++)
                    for (dc = 0; dc < 4; dc++)
                        if ($urandom_range(0, 1))
                            queue_set_cell(r0 + dr, c0 + dc);
            end
            default:
            begin
                queue_set_cell(r0, c0);
            end
        endcase
    endtask

    // Reads mostly probe the neighborhood of the last pattern, where cells
    // are likely to be alive; the rest land anywhere in the grid.
    task automatic queue_probe(input int r0, input int c0);
        int r;
        int c;
        if ($urandom_range(0, 9) < 7)
        begin
            r = r0 + $urandom_range(0, 5) - 1;
            c = c0 + $urandom_range(0, 5) - 1;
            if (r >= 0 && r < GRID && c >= 0 && c < GRID)
            begin
                queue_request(ACT_READ, 16'(r * GRID + c), 1'b0);
                return;
            end
        end
        queue_request(ACT_READ, 16'($urandom_range(0, GRID_AREA - 1)), 1'b0);
    endtask

    // One well-formed episode: optional clear, a few patterns, then a few
    // generations, each followed by reads.
    task automatic queue_life_episode();
        int r0;
        int c0;
        r0 = 0;
        c0 = 0;
        if ($urandom_range(0, 2) == 0)
            queue_request(ACT_CLEAR, 16'($urandom_range(0, 16'hFFFF)), 1'b0);
        repeat ($urandom_range(1, 3))
        begin
            r0 = $urandom_range(0, GRID + 1) - 2;
            c0 = $urandom_range(0, GRID + 1) - 2;
            queue_pattern($urandom_range(PAT_BLINKER, PAT_SINGLE), r0, c0);
        end
        repeat ($urandom_range(1, 4))
        begin
            queue_request(ACT_ADVANCE, 16'($urandom_range(0, 16'hFFFF)),
                          $urandom_range(0, 29) == 0);
            repeat ($urandom_range(1, 4))
                queue_probe(r0, c0);
        end
    endtask

    // Noise: any action with any offset, in range or far beyond it.
    task automatic queue_noise();
        logic [15:0] off;
        repeat ($urandom_range(1, 6))
        begin
            if ($urandom_range(0, 1))
                off = 16'($urandom_range(0, 16'hFFFF));
            else if ($urandom_range(0, 3) == 0)
                off = 16'($urandom_range(GRID_AREA, GRID_AREA + 3));
            else
                off = 16'($urandom_range(0, GRID_AREA - 1));
            queue_request(action_t'($urandom_range(0, 3)), off, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------

    // Gaps are mostly short with an occasional long one; every so often a
    // stretch runs back to back with no gaps at all.
    function automatic int pick_gap();
        int roll;
        if (mode_left == 0)
        begin
            mode_left      = $urandom_range(20, 80);
            no_gap_stretch = ($urandom_range(0, 2) == 0);
        end
        mode_left--;
        if (no_gap_stretch)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        cell_answer_t  ans;
        life_request_t req;
        logic          presenting;
        bit            just_taken;
        int            r;
        presenting = start;
        just_taken = 1'b0;
        if (!rst_n)
        begin
            start          <= 1'b0;
            action         <= ACT_CLEAR;
            cell_offset    <= '0;
            requests_taken <= 0;
            gap_left = 0;
            for (r = 0; r < GRID; r++)
                shadow_rows[r] = '0;
        end
        else
        begin
            if (start && !busy)
            begin
                // The request is taken at this edge; its answer follows the
                // shadow grid as it stands now, since results come back in order.
                apply_to_shadow_grid(action_t'(action), cell_offset, ans);
                awaited_answers.push_back(ans);
                requests_taken <= requests_taken + 1;
                presenting = 1'b0;
                just_taken = 1'b1;
                gap_left   = pick_gap();
            end
            if (!presenting)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_reqs.size() != 0)
                begin
                    // A drain request waits until every answer is in. The
                    // answer count is registered behind done, which only makes
                    // the wait longer.
                    if (!(pending_reqs[0].drain &&
                          (just_taken || requests_taken != answers_seen)))
                    begin
                        req = pending_reqs.pop_front();
                        action      <= req.act;
                        cell_offset <= req.offset;
                        presenting = 1'b1;
                    end
                end
            end
            start <= presenting;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and watchdog
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : check_answers
        cell_answer_t want;
        if (!rst_n)
        begin
            answers_seen <= 0;
        end
        else if (done)
        begin
            answers_seen <= answers_seen + 1;
            if (awaited_answers.size() == 0)
            begin
                report_mismatch($sformatf("result (status %b, cell_alive %b) with no request open",
                                          status, cell_alive));
            end
            else
            begin
                want = awaited_answers.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("%s offset %0d: status %b, expected %b",
                                              want.act.name(), want.offset, status,
                                              want.status));
                if (cell_alive !== want.alive)
                    report_mismatch($sformatf("%s offset %0d: cell_alive %b, expected %b",
                                              want.act.name(), want.offset, cell_alive,
                                              want.alive));
            end
        end
    end

    // Ends the run when neither side makes progress for too long. The
    // slowest legal stretch is a long sender gap plus one generation step.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] watchdog: no request or result for %0d cycles",
                     $realtime, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Directed list, random episodes, and the end of the run
    // ------------------------------------------------------------------------

    initial
    begin : run_test
        int directed_count;
        // Fresh grid is all dead; grid corners and the first offset past the
        // grid, plus the very largest offset, for both set and read.
        queue_request(ACT_READ, 16'd0, 1'b0);
        queue_request(ACT_READ, 16'(GRID_AREA - 1), 1'b0);
        queue_request(ACT_READ, 16'(GRID_AREA), 1'b0);
        queue_request(ACT_SET, 16'hFFFF, 1'b0);
        queue_request(ACT_SET, 16'(GRID_AREA), 1'b0);
        queue_request(ACT_READ, 16'hFFFF, 1'b0);
        queue_request(ACT_SET, 16'd0, 1'b0);
        queue_request(ACT_SET, 16'(GRID_AREA - 1), 1'b0);
        queue_request(ACT_READ, 16'd0, 1'b0);
        queue_request(ACT_READ, 16'(GRID_AREA - 1), 1'b0);
        // Lone corner cells die; the offset of an advance is ignored.
        queue_request(ACT_ADVANCE, 16'hFFFF, 1'b0);
        queue_request(ACT_READ, 16'd0, 1'b0);
        queue_request(ACT_READ, 16'(GRID_AREA - 1), 1'b0);
        // A blinker along the top edge: the cell below is born, the one that
        // would appear on the bottom row under wrap-around must not be.
        queue_request(ACT_SET, 16'd0, 1'b0);
        queue_request(ACT_SET, 16'd1, 1'b0);
        queue_request(ACT_SET, 16'd2, 1'b0);
        queue_request(ACT_ADVANCE, 16'd0, 1'b0);
        queue_request(ACT_READ, 16'd1, 1'b0);
        queue_request(ACT_READ, 16'(GRID + 1), 1'b0);
        queue_request(ACT_READ, 16'((GRID - 1) * GRID + 1), 1'b0);
        queue_request(ACT_READ, 16'd0, 1'b0);
        // Clear with a stray offset, sent only once the block has gone quiet.
        queue_request(ACT_CLEAR, 16'hA5A5, 1'b1);
        queue_request(ACT_READ, 16'd1, 1'b0);
        queue_request(ACT_CLEAR, 16'd0, 1'b0);
        queue_request(ACT_ADVANCE, 16'h5A5A, 1'b0);
        directed_count = pending_reqs.size();

        while (pending_reqs.size() < directed_count + RANDOM_REQS)
        begin
            if ($urandom_range(0, 9) < 7)
                queue_life_episode();
            else
                queue_noise();
        end

        // Decide the end at falling edges, when every request and result of
        // the preceding rising edge has settled.
        wait (rst_n === 1'b1);
        while (pending_reqs.size() != 0 || start || requests_taken != answers_seen)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
        if (awaited_answers.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      awaited_answers.size()));
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
